// ===== src/dlsq_pkg.sv =====
// shared types and constants for the delta list sleep queue
package dlsq_pkg;

    // result status codes
    localparam logic [2:0] ST_WOKEN    = 3'd0;
    localparam logic [2:0] ST_ENQUEUED = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;

    // input operation codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_ENQUEUE = 1'b1;

    // wakes released by one tick at most
    localparam int MAX_WAKE = 16;
    localparam int WAKE_W   = $clog2(MAX_WAKE + 1);

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_ENQ,
        CMD_ZERO
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  task_id;
        logic [15:0] delay;
    } cmd_t;

endpackage

// ===== src/delta_list_sleep_queue.sv =====
// top level of the delta list sleep queue
// A word is taken when start is high and busy is low; a two-word queue sits
// between the front end and the list engine, so busy rises only when both
// slots hold words. Every word yields one or more results, each shown for
// exactly one cycle with result_valid high; last marks the final one. The
// receiver cannot hold results off, so it must take every strobed word.
// A zero delay, full queue or tick without wake is answered straight from the
// engine's idle state. An enqueue walks the list, checking one entry per cycle,
// and is answered once it finds its slot or the end of the list. A tick that
// wakes tasks pops them from the head, one result each. Up to 16 tasks wake on
// one tick; zero-delta entries left at the head wake on the next tick.
module delta_list_sleep_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [7:0]  task_id,
    input  logic [15:0] delay_ticks,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [7:0]  woken_task,
    output logic        last
);

    // command word between front end and engine
    logic           cmd_valid;
    logic           cmd_pop;
    dlsq_pkg::cmd_t cmd;

    dlsq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .task_id     (task_id),
        .delay_ticks (delay_ticks),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    dlsq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .status       (status),
        .woken_task   (woken_task),
        .last         (last)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status <= dlsq_pkg::ST_IDLE)
        else $error("bad status code");
    a_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != dlsq_pkg::ST_WOKEN) |-> woken_task == 8'd0 && last)
        else $error("non-wake result malformed");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last && status != dlsq_pkg::ST_WOKEN && !cmd_valid)
        |=> !result_valid)
        else $error("result without word");

endmodule

// ===== src/dlsq_front.sv =====
// front end: accepts words, classifies them and holds them in a two-word queue
module dlsq_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [7:0]         task_id,
    input  logic [15:0]        delay_ticks,
    output logic               cmd_valid,
    output dlsq_pkg::cmd_t     cmd,
    input  logic               cmd_pop
);

    dlsq_pkg::cmd_t fifo_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    dlsq_pkg::cmd_t new_cmd;
    logic           push;
    logic           pop;

    assign busy      = (fill_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = fifo_reg[rd_ptr_reg];

    // classify on entry
    always_comb
    begin
        new_cmd.task_id = task_id;
        new_cmd.delay   = delay_ticks;
        if (operation == dlsq_pkg::OP_TICK)
            new_cmd.kind = dlsq_pkg::CMD_TICK;
        else if (delay_ticks == 16'd0)
            new_cmd.kind = dlsq_pkg::CMD_ZERO;
        else
            new_cmd.kind = dlsq_pkg::CMD_ENQ;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= new_cmd;
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !push)
        else $error("push into full queue");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> fill_reg == $past(fill_reg) - 2'd1)
        else $error("pop did not drain queue");

endmodule

// ===== src/dlsq_back.sv =====
// back end: walks the delta list, inserts, ticks and pops woken tasks
module dlsq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  dlsq_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           result_valid,
    output logic [2:0]     status,
    output logic [7:0]     woken_task,
    output logic           last
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_POP
    } state_t;

    state_t      state_reg;
    logic [CW-1:0]  count_reg;
    logic [IW-1:0]  pos_reg;
    logic [15:0]    remain_reg;
    logic [7:0]     task_hold_reg;
    logic [dlsq_pkg::WAKE_W-1:0] popped_reg;
    logic           result_valid_reg;
    logic [2:0]     status_reg;
    logic [7:0]     woken_task_reg;
    logic           last_reg;

    logic [7:0]     task_mem [QUEUE_DEPTH];
    logic [15:0]    delta_mem [QUEUE_DEPTH];

    logic [15:0]    cur_delta;
    logic           at_end;
    logic           fits;
    logic [15:0]    head_dec;
    logic           do_insert;
    logic           do_pop;
    logic           do_dec;
    logic           pop_last;

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign cur_delta = delta_mem[pos_reg];
    assign at_end    = (CW'(pos_reg) == count_reg);
    assign fits      = at_end || (remain_reg <= cur_delta);
    assign head_dec  = (delta_mem[0] != 16'd0) ? delta_mem[0] - 16'd1 : 16'd0;
    assign do_insert = (state_reg == S_WALK) && fits;
    assign do_pop    = (state_reg == S_POP);
    assign do_dec    = cmd_pop && (cmd.kind == dlsq_pkg::CMD_TICK) && (count_reg != '0);
    assign pop_last  = (count_reg == CW'(1)) || (delta_mem[1] != 16'd0)
                       || (popped_reg == dlsq_pkg::WAKE_W'(dlsq_pkg::MAX_WAKE - 1));

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign woken_task   = woken_task_reg;
    assign last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            pos_reg          <= '0;
            remain_reg       <= '0;
            task_hold_reg    <= '0;
            popped_reg       <= '0;
            result_valid_reg <= 1'b0;
            status_reg       <= dlsq_pkg::ST_IDLE;
            woken_task_reg   <= '0;
            last_reg         <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (cmd.kind)
                            dlsq_pkg::CMD_ZERO:
                            begin
                                result_valid_reg <= 1'b1;
                                status_reg       <= dlsq_pkg::ST_ZERO;
                                woken_task_reg   <= '0;
                                last_reg         <= 1'b1;
                            end
                            dlsq_pkg::CMD_ENQ:
                            begin
                                if (count_reg >= CW'(QUEUE_DEPTH))
                                begin
                                    result_valid_reg <= 1'b1;
                                    status_reg       <= dlsq_pkg::ST_FULL;
                                    woken_task_reg   <= '0;
                                    last_reg         <= 1'b1;
                                end
                                else
                                begin
                                    pos_reg       <= '0;
                                    remain_reg    <= cmd.delay;
                                    task_hold_reg <= cmd.task_id;
                                    state_reg     <= S_WALK;
                                end
                            end
                            default:
                            begin
                                if (count_reg == '0 || head_dec != 16'd0)
                                begin
                                    result_valid_reg <= 1'b1;
                                    status_reg       <= dlsq_pkg::ST_IDLE;
                                    woken_task_reg   <= '0;
                                    last_reg         <= 1'b1;
                                end
                                else
                                begin
                                    popped_reg <= '0;
                                    state_reg  <= S_POP;
                                end
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    if (fits)
                    begin
                        count_reg        <= count_reg + CW'(1);
                        result_valid_reg <= 1'b1;
                        status_reg       <= dlsq_pkg::ST_ENQUEUED;
                        woken_task_reg   <= '0;
                        last_reg         <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        remain_reg <= remain_reg - cur_delta;
                        pos_reg    <= pos_reg + IW'(1);
                    end
                end
                S_POP:
                begin
                    count_reg        <= count_reg - CW'(1);
                    popped_reg       <= popped_reg + dlsq_pkg::WAKE_W'(1);
                    result_valid_reg <= 1'b1;
                    status_reg       <= dlsq_pkg::ST_WOKEN;
                    woken_task_reg   <= task_mem[0];
                    last_reg         <= pop_last;
                    if (pop_last)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // entry storage: decrements the head on a tick, shifts up on insert, down on pop
    always_ff @(posedge clk)
    begin
        if (do_dec)
            delta_mem[0] <= head_dec;
        if (do_insert)
        begin
            task_mem[pos_reg]  <= task_hold_reg;
            delta_mem[pos_reg] <= remain_reg;
            for (int i = 1; i < QUEUE_DEPTH; i++)
            begin
                if (IW'(i) > pos_reg && CW'(i) <= count_reg)
                begin
                    task_mem[i] <= task_mem[i-1];
                    if (IW'(i - 1) == pos_reg)
                        delta_mem[i] <= delta_mem[i-1] - remain_reg;
                    else
                        delta_mem[i] <= delta_mem[i-1];
                end
            end
        end
        if (do_pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                task_mem[i]  <= task_mem[i+1];
                delta_mem[i] <= delta_mem[i+1];
            end
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond depth");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> CW'(pos_reg) <= count_reg)
        else $error("walk ran past the list");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |-> count_reg != '0)
        else $error("pop on empty list");
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow list");

endmodule
